// ===== rtl/core/assert_macros.svh =====
// assertion macros for the core rtl
// no dependencies; included inside module bodies that check their own logic
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// antecedent implies consequent in the same cycle
`define RDE_ASSERT_IMP(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define RDE_ASSERT_NXT(label, clk, rst_n, ante, cons) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error("assertion failed");

`endif

// ===== rtl/core/rde_pkg.sv =====
// shared types and constants for the radix digit emitter
// no dependencies; imported by rde_cell, radix_digit_emitter and tb_top
package rde_pkg;

  localparam int BASE_W     = 6;
  localparam int CHUNK_W    = 8;
  localparam int CFG_IDX_W  = 3;
  localparam int CNT_W      = 7;
  localparam int TBL_WORDS  = 5;

  localparam logic [BASE_W-1:0] BASE_MIN   = 6'd2;
  localparam logic [BASE_W-1:0] BASE_MAX   = 6'd40;
  localparam logic [BASE_W-1:0] BASE_RESET = 6'd10;

  localparam logic [CFG_IDX_W-1:0] REG_BASE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE0 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE1 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE2 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE3 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_TABLE4 = 3'd5;

  // partial remainder of one division pass, moving down the chain
  typedef struct packed {
    logic              vld;
    logic              nz;
    logic [BASE_W-1:0] rem;
  } digit_tok_t;

  typedef struct packed {
    logic load;
    logic flush;
    logic adv;
  } cell_ctl_t;

endpackage

// ===== rtl/core/rde_cell.sv =====
// one chunk of the number being divided; long-division step on its bits
// depends on rde_pkg
module rde_cell (
  input  logic                                clk,
  input  logic                                rst_n,
  input  rde_pkg::cell_ctl_t                  ctl,
  input  logic [rde_pkg::BASE_W-1:0]          base,
  input  logic [rde_pkg::CHUNK_W-1:0]         load_chunk,
  input  rde_pkg::digit_tok_t                 tok_in,
  output rde_pkg::digit_tok_t                 tok_out
);
  import rde_pkg::*;

  logic [CHUNK_W-1:0] chunk_r, chunk_nxt;
  digit_tok_t         tok_r, tok_nxt;
  logic [CHUNK_W-1:0] quo;
  logic [BASE_W-1:0]  rem;
  logic [BASE_W:0]    trial;

  // restoring division of {remainder in, chunk} by the base
  always_comb begin
    quo   = '0;
    rem   = tok_in.rem;
    trial = '0;
    for (int k = CHUNK_W - 1; k >= 0; k--) begin
      trial = {rem, chunk_r[k]};
      if (trial >= {1'b0, base}) begin
        quo[k] = 1'b1;
        rem    = BASE_W'(trial - {1'b0, base});
      end else begin
        quo[k] = 1'b0;
        rem    = trial[BASE_W-1:0];
      end
    end
  end

  always_comb begin
    chunk_nxt = chunk_r;
    tok_nxt   = tok_r;
    if (ctl.load) begin
      chunk_nxt   = load_chunk;
      tok_nxt.vld = 1'b0;
    end else if (ctl.flush) begin
      tok_nxt.vld = 1'b0;
    end else if (ctl.adv) begin
      if (tok_in.vld) begin
        chunk_nxt   = quo;
        tok_nxt.vld = 1'b1;
        tok_nxt.nz  = tok_in.nz | (quo != '0);
        tok_nxt.rem = rem;
      end else begin
        tok_nxt.vld = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    chunk_r     <= chunk_nxt;
    tok_r.nz    <= tok_nxt.nz;
    tok_r.rem   <= tok_nxt.rem;
    if (!rst_n) begin
      tok_r.vld <= 1'b0;
    end else begin
      tok_r.vld <= tok_nxt.vld;
    end
  end

  assign tok_out = tok_r;

endmodule

// ===== rtl/core/radix_digit_emitter.sv =====
// radix digit emitter top level: config registers, cell chain, output register
// depends on rde_pkg, rde_cell and assert_macros.svh
//
// The number is held in a chain of NUM_CELLS = ceil(NUMBER_WIDTH/8) cells of
// eight bits each. Every cycle that the chain is not stalled, a new division
// pass enters the top cell and each pass moves one cell down, so the passes
// form a wavefront: the first pass to leave the bottom cell puts the first
// digit into the output register, then one digit follows per cycle while the
// output is not stalled. The next number is taken only after the last digit
// of the current one has been emitted. A stalled output freezes the whole
// chain. Digits come out least significant first; the table resets to zeros
// and must be loaded before use.
module radix_digit_emitter #(
  parameter int NUMBER_WIDTH = 64
) (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  output logic                               in_ready,
  input  logic [63:0]                        in_number,
  output logic                               out_valid,
  input  logic                               out_ready,
  output logic [7:0]                         out_digit_char,
  output logic                               out_is_last,
  output logic [6:0]                         out_digit_count,
  input  logic                               cfg_valid,
  output logic                               cfg_ready,
  input  logic [rde_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [63:0]                        cfg_data
);
  import rde_pkg::*;

  localparam int NUM_CELLS = (NUMBER_WIDTH + CHUNK_W - 1) / CHUNK_W;
  localparam int PAD_W     = NUM_CELLS * CHUNK_W;

  logic [BASE_W-1:0] base_r, base_nxt;
  logic [63:0]       table_r [TBL_WORDS];
  logic [63:0]       table_nxt [TBL_WORDS];
  logic [BASE_W-1:0] eff_base;

  logic              busy_r, busy_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic              out_valid_r, out_valid_nxt;
  logic [7:0]        out_char_r, out_char_nxt;
  logic              out_last_r, out_last_nxt;
  logic [CNT_W-1:0]  out_count_r, out_count_nxt;

  logic              in_fire, adv, emit, emit_last;
  logic [7:0]        digit_char;
  logic [63:0]       sel_word;
  logic [PAD_W-1:0]  num_pad;
  cell_ctl_t         ctl;
  digit_tok_t        inject_tok;
  digit_tok_t        tok [NUM_CELLS];
  logic [NUM_CELLS-1:0] tok_vld;

  // configuration
  assign cfg_ready = rst_n;

  always_comb begin
    base_nxt = base_r;
    for (int w = 0; w < TBL_WORDS; w++) begin
      table_nxt[w] = table_r[w];
    end
    if (cfg_valid) begin
      unique case (cfg_index)
        REG_BASE:   base_nxt     = cfg_data[BASE_W-1:0];
        REG_TABLE0: table_nxt[0] = cfg_data;
        REG_TABLE1: table_nxt[1] = cfg_data;
        REG_TABLE2: table_nxt[2] = cfg_data;
        REG_TABLE3: table_nxt[3] = cfg_data;
        REG_TABLE4: table_nxt[4] = cfg_data;
        default: begin
        end
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      base_r <= BASE_RESET;
      for (int w = 0; w < TBL_WORDS; w++) begin
        table_r[w] <= '0;
      end
    end else begin
      base_r <= base_nxt;
      for (int w = 0; w < TBL_WORDS; w++) begin
        table_r[w] <= table_nxt[w];
      end
    end
  end

  always_comb begin
    if (base_r < BASE_MIN) begin
      eff_base = BASE_MIN;
    end else if (base_r > BASE_MAX) begin
      eff_base = BASE_MAX;
    end else begin
      eff_base = base_r;
    end
  end

  // control
  assign in_ready  = rst_n && !busy_r;
  assign in_fire   = in_valid && in_ready;
  assign adv       = busy_r && (!out_valid_r || out_ready);
  assign emit      = adv && tok[0].vld;
  assign emit_last = emit && !tok[0].nz;

  assign ctl.load  = in_fire;
  assign ctl.flush = emit_last;
  assign ctl.adv   = adv;

  assign inject_tok.vld = busy_r;
  assign inject_tok.nz  = 1'b0;
  assign inject_tok.rem = '0;

  assign num_pad = PAD_W'(in_number[NUMBER_WIDTH-1:0]);

  // cell chain, top cell holds the most significant chunk
  for (genvar i = 0; i < NUM_CELLS; i++) begin : g_cell
    digit_tok_t cell_in;
    if (i == NUM_CELLS - 1) begin : g_top
      assign cell_in = inject_tok;
    end else begin : g_mid
      assign cell_in = tok[i+1];
    end
    rde_cell u_cell (
      .clk        (clk),
      .rst_n      (rst_n),
      .ctl        (ctl),
      .base       (eff_base),
      .load_chunk (num_pad[i*CHUNK_W +: CHUNK_W]),
      .tok_in     (cell_in),
      .tok_out    (tok[i])
    );
    assign tok_vld[i] = tok[i].vld;
  end

  // digit table lookup
  always_comb begin
    case (tok[0].rem[BASE_W-1:3])
      3'd0:    sel_word = table_r[0];
      3'd1:    sel_word = table_r[1];
      3'd2:    sel_word = table_r[2];
      3'd3:    sel_word = table_r[3];
      3'd4:    sel_word = table_r[4];
      default: sel_word = '0;
    endcase
    digit_char = sel_word[{tok[0].rem[2:0], 3'b000} +: 8];
  end

  always_comb begin
    busy_nxt      = busy_r;
    cnt_nxt       = cnt_r;
    out_valid_nxt = out_valid_r;
    out_char_nxt  = out_char_r;
    out_last_nxt  = out_last_r;
    out_count_nxt = out_count_r;
    if (out_ready) begin
      out_valid_nxt = 1'b0;
    end
    if (in_fire) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end
    if (emit) begin
      out_valid_nxt = 1'b1;
      out_char_nxt  = digit_char;
      out_last_nxt  = !tok[0].nz;
      out_count_nxt = CNT_W'(cnt_r + 1'b1);
      cnt_nxt       = CNT_W'(cnt_r + 1'b1);
      if (emit_last) begin
        busy_nxt = 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    cnt_r       <= cnt_nxt;
    out_char_r  <= out_char_nxt;
    out_last_r  <= out_last_nxt;
    out_count_r <= out_count_nxt;
    if (!rst_n) begin
      busy_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      busy_r      <= busy_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  assign out_valid       = out_valid_r;
  assign out_digit_char  = out_char_r;
  assign out_is_last     = out_last_r;
  assign out_digit_count = out_count_r;

  `include "assert_macros.svh"

  `RDE_ASSERT_IMP(a_idle_chain_empty, clk, rst_n, !busy_r, tok_vld == '0)
  `RDE_ASSERT_NXT(a_load_starts, clk, rst_n, in_fire, busy_r && cnt_r == '0)
  `RDE_ASSERT_NXT(a_last_ends, clk, rst_n, emit_last, !busy_r && out_valid_r && out_last_r)

endmodule

// ===== tb/tb_top.sv =====
// self-checking testbench for radix_digit_emitter: random idling on the number and digit channels
// predicts every digit beat from a local copy of base and digit table; uses rde_pkg
module tb_top;
  timeunit 1ns;
  timeprecision 1ps;
  import rde_pkg::*;

  localparam logic [CFG_IDX_W-1:0] REG_SPARE6 = 3'd6;
  localparam logic [CFG_IDX_W-1:0] REG_SPARE7 = 3'd7;
  localparam int CYCLE_LIMIT = 400000;
  localparam int TAIL_CYCLES = 100;
  localparam int MAX_DIGITS  = 64;
  localparam int PRINT_CAP   = 50;

  typedef struct packed {
    logic [7:0]       ch;
    logic             last;
    logic [CNT_W-1:0] count;
  } digit_beat_t;

  logic                 clk = 1'b0;
  logic                 rst_n = 1'b0;
  logic                 in_valid = 1'b0;
  logic                 in_ready;
  logic [63:0]          in_number = '0;
  logic                 out_valid;
  logic                 out_ready = 1'b0;
  logic [7:0]           out_digit_char;
  logic                 out_is_last;
  logic [6:0]           out_digit_count;
  logic                 cfg_valid = 1'b0;
  logic                 cfg_ready;
  logic [CFG_IDX_W-1:0] cfg_index = '0;
  logic [63:0]          cfg_data = '0;

  logic [BASE_W-1:0] base_reg = BASE_RESET;
  logic [63:0]       digit_table [TBL_WORDS] = '{default: '0};
  logic [63:0]       number_queue [$];
  digit_beat_t       expected_digits [$];
  bit                idling = 1'b1;
  int                errors = 0;
  int                cycles = 0;
  int                in_gap = 0;
  int                out_gap = 0;

  radix_digit_emitter dut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_number       (in_number),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digit_char  (out_digit_char),
    .out_is_last     (out_is_last),
    .out_digit_count (out_digit_count),
    .cfg_valid       (cfg_valid),
    .cfg_ready       (cfg_ready),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data)
  );

  initial begin
    forever #2 clk = ~clk;
  end

  function automatic void push_digits_of(logic [63:0] number);
    logic [63:0] rest;
    logic [63:0] radix;
    logic [63:0] rem;
    digit_beat_t beat;
    int          n_digits;
    rest = number;
    if (base_reg < BASE_MIN) begin
      radix = 64'(BASE_MIN);
    end else if (base_reg > BASE_MAX) begin
      radix = 64'(BASE_MAX);
    end else begin
      radix = 64'(base_reg);
    end
    n_digits = 0;
    do begin
      rem = rest % radix;
      rest = rest / radix;
      beat.ch = digit_table[rem[5:3]][8*rem[2:0] +: 8];
      beat.last = (rest == 0);
      beat.count = CNT_W'(n_digits + 1);
      expected_digits.push_back(beat);
      n_digits++;
    end while (rest != 0 && n_digits < MAX_DIGITS);
  endfunction

  task automatic report_mismatch(string what, logic [63:0] got, logic [63:0] want);
    if (errors < PRINT_CAP) begin
      $display("mismatch on %s: got %0h, expected %0h at cycle %0d", what, got, want, cycles);
    end
    errors++;
  endtask

  // sender
  always @(posedge clk) begin
    if (!rst_n) begin
      in_valid <= 1'b0;
      in_gap <= 0;
    end else begin
      if (in_valid && in_ready) begin
        push_digits_of(in_number);
      end
      if (!in_valid || in_ready) begin
        if (in_gap != 0) begin
          in_valid <= 1'b0;
          in_gap <= in_gap - 1;
        end else if (idling && number_queue.size() != 0 && $urandom_range(0, 3) == 0) begin
          in_valid <= 1'b0;
          in_gap <= $urandom_range(0, 3);
        end else if (number_queue.size() != 0) begin
          in_valid <= 1'b1;
          in_number <= number_queue.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  // receiver and checker
  always @(posedge clk) begin : digit_monitor
    digit_beat_t want;
    if (!rst_n) begin
      out_ready <= 1'b0;
      out_gap <= 0;
    end else begin
      if (out_valid && out_ready) begin
        if (expected_digits.size() == 0) begin
          report_mismatch("digit beat with none expected", 64'(out_digit_char), '0);
        end else begin
          want = expected_digits.pop_front();
          if (out_digit_char !== want.ch) begin
            report_mismatch("digit_char", 64'(out_digit_char), 64'(want.ch));
          end
          if (out_is_last !== want.last) begin
            report_mismatch("is_last", 64'(out_is_last), 64'(want.last));
          end
          if (out_digit_count !== want.count) begin
            report_mismatch("digit_count", 64'(out_digit_count), 64'(want.count));
          end
        end
      end
      if (out_gap != 0) begin
        out_ready <= 1'b0;
        out_gap <= out_gap - 1;
      end else if (idling && $urandom_range(0, 4) == 0) begin
        out_ready <= 1'b0;
        out_gap <= $urandom_range(0, 3);
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles == CYCLE_LIMIT) begin
      $display("Some tests failed");
      $finish;
    end
  end

  task automatic wait_drained();
    do @(negedge clk);
    while (number_queue.size() != 0 || in_valid || expected_digits.size() != 0);
  endtask

  // called at a rising edge; leaves cfg_valid high for a following write
  task automatic cfg_write(logic [CFG_IDX_W-1:0] idx, logic [63:0] data);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    do @(posedge clk);
    while (!cfg_ready);
    case (idx) inside
      REG_BASE: base_reg = data[BASE_W-1:0];
      REG_TABLE0, REG_TABLE1, REG_TABLE2, REG_TABLE3, REG_TABLE4:
        digit_table[idx - REG_TABLE0] = data;
      default: ;
    endcase
  endtask

  task automatic reconfigure_begin();
    wait_drained();
    @(posedge clk);
  endtask

  task automatic reconfigure_end();
    cfg_valid <= 1'b0;
    @(negedge clk);
  endtask

  task automatic set_base(logic [63:0] data);
    reconfigure_begin();
    cfg_write(REG_BASE, data);
    reconfigure_end();
  endtask

  function automatic logic [63:0] random_number();
    logic [63:0] value;
    value = {$urandom, $urandom};
    case ($urandom_range(0, 3))
      0: random_number = value;
      1: random_number = value >> $urandom_range(0, 63);
      2: random_number = 64'($urandom_range(0, 50));
      default: random_number = value >> $urandom_range(32, 63);
    endcase
  endfunction

  initial begin
    string       digits_text;
    logic [63:0] word;
    logic [63:0] data;
    digits_text = "0123456789ABCDEFGHIJKLMNOPQRSTUVWXYZabcd";
    repeat (4) @(posedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // unloaded table and reset base: every digit reads as code zero
    number_queue = '{64'd0, 64'd9, 64'd10, '1};

    reconfigure_begin();
    for (int w = 0; w < TBL_WORDS; w++) begin
      for (int k = 0; k < 8; k++) word[8*k +: 8] = digits_text[8*w + k];
      cfg_write(CFG_IDX_W'(REG_TABLE0 + w), word);
    end
    cfg_write(REG_SPARE6, '1);
    cfg_write(REG_SPARE7, 64'h0123_4567_89ab_cdef);
    cfg_write(REG_BASE, 64'd10);
    reconfigure_end();
    number_queue = '{64'd0, 64'd1, 64'd9, 64'd10, 64'd99, 64'd100,
                     64'd10000000000000000000, '1};

    // upper data bits set, low six bits give base two
    set_base(64'hffff_ffff_ffff_ffc2);
    number_queue = '{'1, 64'h8000_0000_0000_0000, 64'd1};

    set_base(64'd40);
    number_queue = '{'1, 64'd39, 64'd40, 64'd1599, 64'd1600};

    // out-of-range bases clamp to two and forty
    set_base(64'd0);
    number_queue.push_back(64'd5);
    set_base(64'd1);
    number_queue.push_back(64'd5);
    set_base(64'd63);
    number_queue.push_back(64'd40);
    set_base(64'd41);
    number_queue.push_back(64'd40);

    for (int phase = 0; phase < 6; phase++) begin
      reconfigure_begin();
      data = {$urandom, $urandom};
      if (phase == 0) begin
        data[BASE_W-1:0] = BASE_MIN;
      end else if (phase == 1) begin
        data[BASE_W-1:0] = BASE_MAX;
      end else if ($urandom_range(0, 3) != 0) begin
        data[BASE_W-1:0] = BASE_W'($urandom_range(2, 40));
      end
      cfg_write(REG_BASE, data);
      for (int w = 0; w < TBL_WORDS; w++) begin
        if ($urandom_range(0, 1) == 1) begin
          cfg_write(CFG_IDX_W'(REG_TABLE0 + w), {$urandom, $urandom});
        end
      end
      if ($urandom_range(0, 2) == 0) begin
        cfg_write($urandom_range(0, 1) ? REG_SPARE6 : REG_SPARE7, {$urandom, $urandom});
      end
      if (phase == 5) begin
        idling = 1'b0;
      end
      reconfigure_end();
      for (int i = 0; i < 16; i++) begin
        if (phase == 3 && i == 10) begin
          // hold the sender until every digit so far is back
          wait_drained();
        end
        number_queue.push_back(random_number());
      end
    end

    wait_drained();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
